// ----- design/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, skipped while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/mss_pkg.sv -----
// shared constants for the moisture sample sequencer
package mss_pkg;

  // phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_START    = 3'd1;
  localparam logic [2:0] PH_WAIT     = 3'd2;
  localparam logic [2:0] PH_PROCESS  = 3'd3;
  localparam logic [2:0] PH_REPORT   = 3'd4;
  localparam logic [2:0] PH_INTERVAL = 3'd5;

  // register indexes
  localparam logic [1:0] REG_DRY      = 2'd0;
  localparam logic [1:0] REG_WET      = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;
  localparam logic [1:0] REG_VREF     = 2'd3;

  // register reset values
  localparam logic [11:0] DRY_RESET      = 12'd4095;
  localparam logic [11:0] WET_RESET      = 12'd0;
  localparam logic [31:0] INTERVAL_RESET = 32'd300;
  localparam logic [12:0] VREF_RESET     = 13'd3300;

  // arithmetic constants
  localparam logic [11:0] ADC_FULL  = 12'd4095;
  localparam logic [12:0] PCT_SCALE = 13'd100;
  localparam logic [6:0]  PCT_FULL  = 7'd100;
  localparam logic [4:0]  MUL_LAST  = 5'd12;
  localparam logic [4:0]  DIV_LAST  = 5'd24;

endpackage

// ----- design/moisture_sample_sequencer.sv -----
// moisture sample sequencer: phase control with a bit-serial multiply and divide unit
//
// one poll beat in gives exactly one result beat out. polls enter on in_valid while
// in_stall is low; results leave on out_valid while out_stall is low. in_stall is high
// while a poll is being worked on and during reset. a finished result sits in the
// output register while the next poll is taken.
// from a poll, most phases pass from the idle state to the done state and then the output
// register; the interval phase goes through its compare state first. the process phase
// runs a shift-add multiply and a restoring divide for millivolts, then the same pair for
// the percentage when the sample lies between the wet and dry levels; the divider, which
// gives one quotient bit per cycle, is shared by both values.
// one poll is worked on at a time; the next is taken after the last leaves the done state.
// if out_stall holds a result, a finished poll waits in the core until the output
// register frees up, so nothing is dropped.
// reset returns to the idle phase, clears the latched values and restores the
// default calibration. registers are written through cfg_valid/cfg_ready, which is
// ready every cycle outside reset; write only while no poll is in flight.
module moisture_sample_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] now_ticks,
  input  logic        conversion_done,
  input  logic [11:0] adc_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        start_conversion,
  output logic        report_valid,
  output logic [11:0] raw_reading,
  output logic [6:0]  moisture_percent,
  output logic [12:0] sample_millivolts,
  output logic [2:0]  phase,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] CS_IDLE    = 3'd0;
  localparam logic [2:0] CS_MUL_MV  = 3'd1;
  localparam logic [2:0] CS_DIV_MV  = 3'd2;
  localparam logic [2:0] CS_MUL_PCT = 3'd3;
  localparam logic [2:0] CS_DIV_PCT = 3'd4;
  localparam logic [2:0] CS_INTV    = 3'd5;
  localparam logic [2:0] CS_DONE    = 3'd6;

  logic [11:0] dry_level;
  logic [11:0] wet_level;
  logic [31:0] wait_interval;
  logic [12:0] vref_millivolts;

  logic [2:0]  phase_reg;
  logic [31:0] interval_start;
  logic [11:0] latched_raw;
  logic [6:0]  latched_percent;
  logic [12:0] latched_millivolts;
  logic        start_pulse;
  logic        report_pulse;

  logic [2:0]  cs;
  logic [4:0]  cnt;
  logic [24:0] work;
  logic [24:0] mcand;
  logic [12:0] mplier;
  logic [11:0] rem;
  logic [11:0] divisor;
  logic [31:0] elapsed;

  logic        in_take;
  logic        out_free;
  logic [24:0] mul_sum;
  logic [12:0] div_shift;
  logic        div_ge;
  logic [12:0] div_diff;
  logic [11:0] rem_next;
  logic [24:0] quot_next;
  logic [11:0] dry_minus_raw;

  assign cfg_ready = !rst;
  assign in_stall  = rst || (cs != CS_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // one multiply step and one divide step
  assign mul_sum       = mplier[0] ? (work + mcand) : work;
  assign div_shift     = {rem, work[24]};
  assign div_ge        = div_shift >= {1'b0, divisor};
  assign div_diff      = div_shift - {1'b0, divisor};
  assign rem_next      = div_ge ? div_diff[11:0] : div_shift[11:0];
  assign quot_next     = {work[23:0], div_ge};
  assign dry_minus_raw = dry_level - latched_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_level       <= mss_pkg::DRY_RESET;
      wet_level       <= mss_pkg::WET_RESET;
      wait_interval   <= mss_pkg::INTERVAL_RESET;
      vref_millivolts <= mss_pkg::VREF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mss_pkg::REG_DRY:      dry_level       <= cfg_data[11:0];
        mss_pkg::REG_WET:      wet_level       <= cfg_data[11:0];
        mss_pkg::REG_INTERVAL: wait_interval   <= cfg_data;
        mss_pkg::REG_VREF:     vref_millivolts <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cs                 <= CS_IDLE;
      cnt                <= '0;
      phase_reg          <= mss_pkg::PH_IDLE;
      interval_start     <= '0;
      latched_raw        <= '0;
      latched_percent    <= '0;
      latched_millivolts <= '0;
      start_pulse        <= 1'b0;
      report_pulse       <= 1'b0;
    end else begin
      case (cs)
        CS_IDLE: begin
          if (in_take) begin
            start_pulse  <= 1'b0;
            report_pulse <= 1'b0;
            cs           <= CS_DONE;
            case (phase_reg)
              mss_pkg::PH_START: begin
                start_pulse    <= 1'b1;
                interval_start <= now_ticks;
                phase_reg      <= mss_pkg::PH_WAIT;
              end
              mss_pkg::PH_WAIT: begin
                if (conversion_done) begin
                  phase_reg <= mss_pkg::PH_PROCESS;
                end
              end
              mss_pkg::PH_PROCESS: begin
                latched_raw <= adc_sample;
                phase_reg   <= mss_pkg::PH_REPORT;
                work        <= '0;
                mcand       <= {13'd0, adc_sample};
                mplier      <= vref_millivolts;
                cnt         <= '0;
                cs          <= CS_MUL_MV;
              end
              mss_pkg::PH_REPORT: begin
                report_pulse   <= 1'b1;
                interval_start <= now_ticks;
                phase_reg      <= mss_pkg::PH_INTERVAL;
              end
              mss_pkg::PH_INTERVAL: begin
                elapsed <= now_ticks - interval_start;
                cs      <= CS_INTV;
              end
              default: begin
                phase_reg <= mss_pkg::PH_START;
              end
            endcase
          end
        end
        CS_MUL_MV, CS_MUL_PCT: begin
          work   <= mul_sum;
          mcand  <= {mcand[23:0], 1'b0};
          mplier <= {1'b0, mplier[12:1]};
          cnt    <= cnt + 5'd1;
          if (cnt == mss_pkg::MUL_LAST) begin
            cnt <= '0;
            rem <= '0;
            if (cs == CS_MUL_MV) begin
              divisor <= mss_pkg::ADC_FULL;
              cs      <= CS_DIV_MV;
            end else begin
              divisor <= dry_level - wet_level;
              cs      <= CS_DIV_PCT;
            end
          end
        end
        CS_DIV_MV: begin
          work <= quot_next;
          rem  <= rem_next;
          cnt  <= cnt + 5'd1;
          if (cnt == mss_pkg::DIV_LAST) begin
            latched_millivolts <= quot_next[12:0];
            cnt                <= '0;
            if (latched_raw >= dry_level) begin
              latched_percent <= '0;
              cs              <= CS_DONE;
            end else if (latched_raw <= wet_level) begin
              latched_percent <= mss_pkg::PCT_FULL;
              cs              <= CS_DONE;
            end else begin
              work   <= '0;
              mcand  <= {13'd0, dry_minus_raw};
              mplier <= mss_pkg::PCT_SCALE;
              cs     <= CS_MUL_PCT;
            end
          end
        end
        CS_DIV_PCT: begin
          work <= quot_next;
          rem  <= rem_next;
          cnt  <= cnt + 5'd1;
          if (cnt == mss_pkg::DIV_LAST) begin
            latched_percent <= quot_next[6:0];
            cnt             <= '0;
            cs              <= CS_DONE;
          end
        end
        CS_INTV: begin
          if (elapsed >= wait_interval) begin
            phase_reg <= mss_pkg::PH_IDLE;
          end
          cs <= CS_DONE;
        end
        CS_DONE: begin
          if (out_free) begin
            cs <= CS_IDLE;
          end
        end
        default: begin
          cs <= CS_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cs == CS_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cs == CS_DONE && out_free) begin
      start_conversion  <= start_pulse;
      report_valid      <= report_pulse;
      raw_reading       <= latched_raw;
      moisture_percent  <= latched_percent;
      sample_millivolts <= latched_millivolts;
      phase             <= phase_reg;
    end
  end

endmodule

// ----- design/mss_checker.sv -----
// port-level checks for the moisture sample sequencer, bound to the top level
`include "assert_macros.svh"

module mss_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        start_conversion,
  input logic        report_valid,
  input logic [6:0]  moisture_percent,
  input logic [2:0]  phase
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(phase))
  `ASSERT_NOW(a_pulse_excl, clk, rst, out_valid, !(start_conversion && report_valid))
  `ASSERT_NOW(a_start_phase, clk, rst, out_valid && start_conversion, phase == mss_pkg::PH_WAIT)
  `ASSERT_NOW(a_report_phase, clk, rst, out_valid && report_valid, phase == mss_pkg::PH_INTERVAL)
  `ASSERT_NOW(a_pct_range, clk, rst, out_valid, moisture_percent <= mss_pkg::PCT_FULL)

endmodule

bind moisture_sample_sequencer mss_checker u_mss_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .start_conversion (start_conversion),
  .report_valid     (report_valid),
  .moisture_percent (moisture_percent),
  .phase            (phase)
);
